// ===== rtl/radio_end_device_link_fsm_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Link sequencer assertion macros
// Shared concurrent assertion forms used by the link sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef RADIO_END_DEVICE_LINK_FSM_UNIT_DEFINES_SVH
`define RADIO_END_DEVICE_LINK_FSM_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define REDLF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("link sequencer assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define REDLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("link sequencer assertion failed");

`endif

// ===== rtl/redlf_pkg.sv =====
// ----------------------------------------------------------------------------
// Link sequencer package
// Types, codes and reset values shared by the link sequencer RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package redlf_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned SpanW = 16;
	localparam int unsigned RetryW = 3;
	localparam int unsigned ByteW = 8;

	localparam logic [SpanW-1:0] AssocTimeoutRst = 16'd10000;
	localparam logic [SpanW-1:0] ReplyTimeoutRst = 16'd5000;
	localparam logic [SpanW-1:0] ExpiryWindowRst = 16'd1000;
	localparam logic [RetryW-1:0] MaxRetriesRst = 3'd3;
	localparam logic [RetryW-1:0] RetrySat = 3'd7;

	// Acknowledge byte of a join reply ('K').
	localparam logic [ByteW-1:0] AckByte = 8'h4B;

	typedef enum logic [1:0] {
		CFG_ASSOC_TIMEOUT = 2'd0,
		CFG_REPLY_TIMEOUT = 2'd1,
		CFG_EXPIRY_WINDOW = 2'd2,
		CFG_MAX_RETRIES   = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_JOIN   = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_WAKE   = 2'd3
	} cmd_t;

	localparam logic [2:0] KIND_MODEM  = 3'd0;
	localparam logic [2:0] KIND_TXSTAT = 3'd1;
	localparam logic [2:0] KIND_RXDATA = 3'd2;
	localparam logic [2:0] KIND_ATRESP = 3'd3;

	typedef enum logic [3:0] {
		TC_OK            = 4'd0,
		TC_ASSOC_FAIL    = 4'd1,
		TC_JOIN_UNDELIV  = 4'd2,
		TC_JOIN_TIMEOUT  = 4'd3,
		TC_JOIN_OK       = 4'd4,
		TC_JOIN_BAD      = 4'd5,
		TC_SLEEPING      = 4'd6,
		TC_ERROR         = 4'd7,
		TC_UPD_UNDELIV   = 4'd8,
		TC_UPD_TIMEOUT   = 4'd9,
		TC_NEW_MESSAGE   = 4'd10
	} tick_code_t;

	typedef enum logic [1:0] {
		SEND_NONE  = 2'd0,
		SEND_JOIN  = 2'd1,
		SEND_REQ   = 2'd2,
		SEND_RESET = 2'd3
	} send_kind_t;

	typedef enum logic [3:0] {
		M_START       = 4'd0,
		M_FORMING     = 4'd1,
		M_JOIN_SEND   = 4'd2,
		M_JOIN_WAIT   = 4'd3,
		M_JOIN_REPLY  = 4'd4,
		M_IDLE        = 4'd5,
		M_SLEEP_TELL  = 4'd6,
		M_SLEEP_WAIT  = 4'd7,
		M_SLEEPING    = 4'd8,
		M_ERROR       = 4'd9,
		M_REQ_SEND    = 4'd10,
		M_REQ_STATUS  = 4'd11,
		M_REQ_WAIT    = 4'd12,
		M_RESET_START = 4'd13,
		M_RESET_WAIT  = 4'd14
	} mode_t;

	typedef struct packed {
		logic              radio_awake;
		logic [ByteW-1:0]  rx_last_byte;
		logic [ByteW-1:0]  rx_first_byte;
		logic [ByteW-1:0]  rx_length;
		logic              at_is_reset;
		logic              tx_ok;
		logic              is_associated;
		logic [2:0]        frame_kind;
		logic              frame_valid;
		logic [TimeW-1:0]  now_ms;
	} in_item_t;

	typedef struct packed {
		logic       sleep_request;
		send_kind_t send_kind;
		tick_code_t tick_code;
	} out_item_t;

endpackage

// ===== rtl/radio_end_device_link_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// Radio end device link sequencer
// Steps a radio end device through reset, association, join, idle, sleep and
// update handshakes, one input item per clock.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and returns exactly one result item
// for each. An accepted item is captured in an input register. While it is held
// there, the sequencer logic decides the transition and writes the result
// register once that register can load. That logic is one 33-bit add and two
// 32-bit compares for the deadline test, two 32-bit adds that form the new
// deadlines, and the state selection. The throughput is one item per cycle as
// long as the result side keeps taking items. The result register is
// refilled in the same cycle it is drained, so a result side that takes an item
// every cycle never stalls the input. While a result waits, the input register
// can still take one more item; after that s_tready stays low until the result
// leaves. Tick items advance the sequencer. Join, update and wake requests only
// set pending flags (or, for a join outside sleep, force a network reset) and
// return code zero. The configuration port is always ready and must only be
// written while the block holds no item in flight.
`timescale 1ns / 1ps

`include "radio_end_device_link_fsm_unit_defines.svh"

module radio_end_device_link_fsm_unit
	import redlf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input item stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata, low bit up: now_ms[31:0], frame_valid[32], frame_kind[35:33],
	// is_associated[36], tx_ok[37], at_is_reset[38], rx_length[46:39],
	// rx_first_byte[54:47], rx_last_byte[62:55], radio_awake[63].
	input  logic [63:0] s_tdata,
	// tuser, low bit up: cmd[1:0].
	input  logic [1:0]  s_tuser,
	// Result item stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata, low bit up: tick_code[3:0], send_kind[5:4], sleep_request[6], zero[7].
	output logic [7:0]  m_tdata,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic [SpanW-1:0]  assoc_timeout_q;
	logic [SpanW-1:0]  reply_timeout_q;
	logic [SpanW-1:0]  expiry_window_q;
	logic [RetryW-1:0] max_retries_q;

	// Sequencer state.
	mode_t             mode_q, mode_d;
	logic [TimeW-1:0]  deadline_q, deadline_d;
	logic              armed_q, armed_d;
	logic              update_pend_q, update_pend_d;
	logic              wake_pend_q, wake_pend_d;
	logic              reset_pend_q, reset_pend_d;
	logic [RetryW-1:0] retry_q, retry_d;
	logic              sleep_pin_q, sleep_pin_d;

	// Input and result stages.
	logic      valid_s1;
	in_item_t  item_s1;
	cmd_t      cmd_s1;
	logic      valid_s2;
	out_item_t res_s2;

	tick_code_t code_d;
	send_kind_t send_d;

	logic advance;
	logic s_fire;

	// The result stage can load whenever it is empty or being drained.
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = {1'b0, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assoc_timeout_q <= AssocTimeoutRst;
			reply_timeout_q <= ReplyTimeoutRst;
			expiry_window_q <= ExpiryWindowRst;
			max_retries_q   <= MaxRetriesRst;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_ASSOC_TIMEOUT: assoc_timeout_q <= cfg_data;
				CFG_REPLY_TIMEOUT: reply_timeout_q <= cfg_data;
				CFG_EXPIRY_WINDOW: expiry_window_q <= cfg_data;
				CFG_MAX_RETRIES:   max_retries_q   <= cfg_data[RetryW-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1 <= in_item_t'(s_tdata);
			cmd_s1  <= cmd_t'(s_tuser);
		end
	end

	// Deadline test. The window end may wrap past the top of the time range,
	// in which case the window is the union of the two pieces on either side.
	logic [TimeW:0]   end_sum;
	logic [TimeW-1:0] end_ms;
	logic             after_dl;
	logic             before_end;
	logic             expired;

	always_comb begin
		end_sum    = {1'b0, deadline_q} + {{(TimeW+1-SpanW){1'b0}}, expiry_window_q};
		end_ms     = end_sum[TimeW-1:0];
		after_dl   = item_s1.now_ms > deadline_q;
		before_end = item_s1.now_ms < end_ms;
		if (!armed_q) begin
			expired = 1'b0;
		end else if (end_sum[TimeW]) begin
			expired = after_dl || before_end;
		end else begin
			expired = after_dl && before_end;
		end
	end

	// Next-state and result logic for the item in the input register.
	logic              fv;
	logic [2:0]        kind;
	logic [TimeW-1:0]  arm_assoc;
	logic [TimeW-1:0]  arm_reply;
	logic [RetryW-1:0] retry_inc;

	always_comb begin
		fv        = item_s1.frame_valid;
		kind      = item_s1.frame_kind;
		arm_assoc = item_s1.now_ms + {{(TimeW-SpanW){1'b0}}, assoc_timeout_q};
		arm_reply = item_s1.now_ms + {{(TimeW-SpanW){1'b0}}, reply_timeout_q};
		retry_inc = (retry_q < RetrySat) ? retry_q + 1'b1 : retry_q;

		mode_d        = mode_q;
		deadline_d    = deadline_q;
		armed_d       = armed_q;
		update_pend_d = update_pend_q;
		wake_pend_d   = wake_pend_q;
		reset_pend_d  = reset_pend_q;
		retry_d       = retry_q;
		sleep_pin_d   = sleep_pin_q;
		code_d        = TC_OK;
		send_d        = SEND_NONE;

		case (cmd_s1)
			CMD_JOIN: begin
				if (mode_q == M_SLEEP_WAIT || mode_q == M_SLEEPING) begin
					reset_pend_d = 1'b1;
				end else begin
					mode_d = M_RESET_START;
				end
			end
			CMD_UPDATE: update_pend_d = 1'b1;
			CMD_WAKE:   wake_pend_d = 1'b1;
			default: begin
				case (mode_q)
					M_START: begin
						deadline_d = arm_assoc;
						armed_d    = 1'b1;
						mode_d     = M_FORMING;
					end
					M_FORMING: begin
						if (expired) begin
							code_d = TC_ASSOC_FAIL;
						end else if (fv && kind == KIND_MODEM && item_s1.is_associated) begin
							armed_d = 1'b0;
							mode_d  = M_JOIN_SEND;
						end
					end
					M_JOIN_SEND: begin
						send_d = SEND_JOIN;
						mode_d = M_JOIN_WAIT;
					end
					M_JOIN_WAIT: begin
						if (fv && kind == KIND_TXSTAT) begin
							if (item_s1.tx_ok) begin
								deadline_d = arm_reply;
								armed_d    = 1'b1;
								mode_d     = M_JOIN_REPLY;
							end else begin
								code_d = TC_JOIN_UNDELIV;
							end
						end
					end
					M_JOIN_REPLY: begin
						if (expired) begin
							armed_d = 1'b0;
							mode_d  = M_ERROR;
							code_d  = TC_JOIN_TIMEOUT;
						end else if (fv && kind == KIND_RXDATA) begin
							if (item_s1.rx_length == 8'd1 && item_s1.rx_first_byte == AckByte) begin
								armed_d = 1'b0;
								mode_d  = M_IDLE;
								code_d  = TC_JOIN_OK;
							end else begin
								code_d = TC_JOIN_BAD;
							end
						end
					end
					M_IDLE: begin
						if (update_pend_q) begin
							update_pend_d = 1'b0;
							mode_d        = M_REQ_SEND;
						end else begin
							mode_d = M_SLEEP_TELL;
						end
					end
					M_SLEEP_TELL: begin
						sleep_pin_d = 1'b1;
						wake_pend_d = 1'b0;
						mode_d      = M_SLEEP_WAIT;
					end
					M_SLEEP_WAIT: begin
						if (!fv && !item_s1.radio_awake) begin
							mode_d = M_SLEEPING;
							code_d = TC_SLEEPING;
						end
					end
					M_SLEEPING: begin
						if (!(reset_pend_q || wake_pend_q)) begin
							code_d = TC_SLEEPING;
						end else begin
							sleep_pin_d = 1'b0;
							mode_d      = reset_pend_q ? M_RESET_START : M_IDLE;
						end
					end
					M_REQ_SEND: begin
						send_d = SEND_REQ;
						mode_d = M_REQ_STATUS;
					end
					M_REQ_STATUS: begin
						if (fv && kind == KIND_TXSTAT) begin
							if (item_s1.tx_ok) begin
								deadline_d = arm_reply;
								armed_d    = 1'b1;
								mode_d     = M_REQ_WAIT;
							end else begin
								code_d = TC_UPD_UNDELIV;
							end
						end
					end
					M_REQ_WAIT: begin
						if (expired) begin
							armed_d = 1'b0;
							retry_d = retry_inc;
							if (retry_inc > max_retries_q) begin
								mode_d = M_ERROR;
								code_d = TC_UPD_TIMEOUT;
							end else begin
								mode_d = M_REQ_SEND;
							end
						end else if (fv && kind == KIND_RXDATA) begin
							if (item_s1.rx_length != '0 && item_s1.rx_last_byte == '0) begin
								armed_d = 1'b0;
								mode_d  = M_IDLE;
								code_d  = TC_NEW_MESSAGE;
							end else begin
								deadline_d = arm_reply;
								armed_d    = 1'b1;
							end
						end
					end
					M_RESET_START: begin
						reset_pend_d = 1'b0;
						armed_d      = 1'b0;
						send_d       = SEND_RESET;
						mode_d       = M_RESET_WAIT;
					end
					M_RESET_WAIT: begin
						if (fv && kind == KIND_ATRESP && item_s1.at_is_reset) begin
							mode_d = M_START;
						end
					end
					// The error state and the unused encoding both report an error.
					default: code_d = TC_ERROR;
				endcase
			end
		endcase
	end

	// State and result registers move together when the item leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= M_START;
			deadline_q    <= '0;
			armed_q       <= 1'b0;
			update_pend_q <= 1'b0;
			wake_pend_q   <= 1'b0;
			reset_pend_q  <= 1'b0;
			retry_q       <= '0;
			sleep_pin_q   <= 1'b0;
			valid_s2      <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				mode_q        <= mode_d;
				deadline_q    <= deadline_d;
				armed_q       <= armed_d;
				update_pend_q <= update_pend_d;
				wake_pend_q   <= wake_pend_d;
				reset_pend_q  <= reset_pend_d;
				retry_q       <= retry_d;
				sleep_pin_q   <= sleep_pin_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= '{sleep_request: sleep_pin_d, send_kind: send_d, tick_code: code_d};
		end
	end

	// The sleep request pin is only raised across the sleep handshake.
	`REDLF_ASSERT_NOW(a_sleep_pin_mode, clk, arst_n, sleep_pin_q,
		mode_q == M_SLEEP_WAIT || mode_q == M_SLEEPING)
	// A deadline is armed only in states that watch it, or just before a reset clears it.
	`REDLF_ASSERT_NOW(a_armed_mode, clk, arst_n, armed_q,
		mode_q == M_FORMING || mode_q == M_JOIN_REPLY || mode_q == M_REQ_WAIT ||
		mode_q == M_RESET_START)
	// A result that requests a frame never carries a status code.
	`REDLF_ASSERT_NOW(a_send_code, clk, arst_n, valid_s2 && res_s2.send_kind != SEND_NONE,
		res_s2.tick_code == TC_OK)
	// The retry count only ever grows.
	`REDLF_ASSERT_NEXT(a_retry_mono, clk, arst_n, 1'b1, retry_q >= $past(retry_q))

endmodule

// ===== tb/tb_radio_end_device_link_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// Link sequencer testbench
// Drives request and tick items into the radio end device link sequencer and
// checks every result item against a cycle-free predictor of the sequencer.
// The run covers a directed walk through join, update, sleep and network
// reset, then random phases under several register settings. Both streams
// idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_radio_end_device_link_fsm_unit;
	import redlf_pkg::*;

	// Clock, reset and the ports of the block. Every input has a known value
	// from time zero on.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	cmd_t        s_tuser = CMD_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_ASSOC_TIMEOUT;
	logic [15:0] cfg_data = '0;

	radio_end_device_link_fsm_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted sequencer state. These mirror the registers inside the block
	// and are advanced once for every item accepted on the input stream.
	mode_t       seq_mode;
	logic [31:0] seq_deadline;
	bit          seq_armed;
	bit          seq_update_pending;
	bit          seq_wake_pending;
	bit          seq_reset_pending;
	logic [2:0]  seq_retries;
	bit          seq_sleep_pin;

	// Predicted register contents.
	logic [15:0] reg_assoc_ms;
	logic [15:0] reg_reply_ms;
	logic [15:0] reg_window_ms;
	logic [2:0]  reg_max_retries;

	// Results that the block owes us, oldest first.
	out_item_t   pending_results[$];
	int          mismatches = 0;
	int          results_seen = 0;

	// Stimulus time base and idling controls.
	logic [31:0] radio_ms = 32'd0;
	bit          steady_tx = 1'b0;
	bit          steady_rx = 1'b0;
	int          stall_left = 0;

	function automatic void seq_reset();
		seq_mode = M_START;
		seq_deadline = '0;
		seq_armed = 1'b0;
		seq_update_pending = 1'b0;
		seq_wake_pending = 1'b0;
		seq_reset_pending = 1'b0;
		seq_retries = '0;
		seq_sleep_pin = 1'b0;
		reg_assoc_ms = AssocTimeoutRst;
		reg_reply_ms = ReplyTimeoutRst;
		reg_window_ms = ExpiryWindowRst;
		reg_max_retries = MaxRetriesRst;
	endfunction

	// The deadline counts as passed only inside a window that opens right
	// after it. The window may straddle the 32-bit wrap of the time base.
	function automatic bit deadline_passed(logic [31:0] now);
		logic [31:0] win_end;
		if (!seq_armed)
			return 1'b0;
		win_end = seq_deadline + {16'd0, reg_window_ms};
		if (win_end < seq_deadline)
			return (now > seq_deadline) || (now < win_end);
		return (now > seq_deadline) && (now < win_end);
	endfunction

	function automatic void arm_deadline(logic [31:0] now, logic [15:0] span);
		seq_deadline = now + {16'd0, span};
		seq_armed = 1'b1;
	endfunction

	// Advances the predicted sequencer by one item and returns its result.
	function automatic out_item_t seq_advance(in_item_t it, cmd_t cmd);
		out_item_t  res;
		tick_code_t code;
		send_kind_t send;
		code = TC_OK;
		send = SEND_NONE;
		case (cmd)
			CMD_JOIN: begin
				if (seq_mode == M_SLEEP_WAIT || seq_mode == M_SLEEPING)
					seq_reset_pending = 1'b1;
				else
					seq_mode = M_RESET_START;
			end
			CMD_UPDATE: seq_update_pending = 1'b1;
			CMD_WAKE: seq_wake_pending = 1'b1;
			default: begin
				case (seq_mode)
					M_START: begin
						arm_deadline(it.now_ms, reg_assoc_ms);
						seq_mode = M_FORMING;
					end
					M_FORMING: begin
						if (deadline_passed(it.now_ms))
							code = TC_ASSOC_FAIL;
						else if (it.frame_valid && it.frame_kind == KIND_MODEM &&
							it.is_associated) begin
							seq_armed = 1'b0;
							seq_mode = M_JOIN_SEND;
						end
					end
					M_JOIN_SEND: begin
						send = SEND_JOIN;
						seq_mode = M_JOIN_WAIT;
					end
					M_JOIN_WAIT: begin
						if (it.frame_valid && it.frame_kind == KIND_TXSTAT) begin
							if (it.tx_ok) begin
								arm_deadline(it.now_ms, reg_reply_ms);
								seq_mode = M_JOIN_REPLY;
							end else
								code = TC_JOIN_UNDELIV;
						end
					end
					M_JOIN_REPLY: begin
						if (deadline_passed(it.now_ms)) begin
							seq_armed = 1'b0;
							seq_mode = M_ERROR;
							code = TC_JOIN_TIMEOUT;
						end else if (it.frame_valid && it.frame_kind == KIND_RXDATA) begin
							if (it.rx_length == 8'd1 && it.rx_first_byte == AckByte) begin
								seq_armed = 1'b0;
								seq_mode = M_IDLE;
								code = TC_JOIN_OK;
							end else
								code = TC_JOIN_BAD;
						end
					end
					M_IDLE: begin
						if (seq_update_pending) begin
							seq_update_pending = 1'b0;
							seq_mode = M_REQ_SEND;
						end else
							seq_mode = M_SLEEP_TELL;
					end
					M_SLEEP_TELL: begin
						seq_sleep_pin = 1'b1;
						seq_wake_pending = 1'b0;
						seq_mode = M_SLEEP_WAIT;
					end
					M_SLEEP_WAIT: begin
						if (!it.frame_valid && !it.radio_awake) begin
							seq_mode = M_SLEEPING;
							code = TC_SLEEPING;
						end
					end
					M_SLEEPING: begin
						if (!(seq_reset_pending || seq_wake_pending))
							code = TC_SLEEPING;
						else begin
							seq_sleep_pin = 1'b0;
							seq_mode = seq_reset_pending ? M_RESET_START : M_IDLE;
						end
					end
					M_REQ_SEND: begin
						send = SEND_REQ;
						seq_mode = M_REQ_STATUS;
					end
					M_REQ_STATUS: begin
						if (it.frame_valid && it.frame_kind == KIND_TXSTAT) begin
							if (it.tx_ok) begin
								arm_deadline(it.now_ms, reg_reply_ms);
								seq_mode = M_REQ_WAIT;
							end else
								code = TC_UPD_UNDELIV;
						end
					end
					M_REQ_WAIT: begin
						if (deadline_passed(it.now_ms)) begin
							seq_armed = 1'b0;
							if (seq_retries < RetrySat)
								seq_retries = seq_retries + 3'd1;
							if (seq_retries > reg_max_retries) begin
								seq_mode = M_ERROR;
								code = TC_UPD_TIMEOUT;
							end else
								seq_mode = M_REQ_SEND;
						end else if (it.frame_valid && it.frame_kind == KIND_RXDATA) begin
							seq_armed = 1'b0;
							if (it.rx_length != 8'd0 && it.rx_last_byte == 8'd0) begin
								seq_mode = M_IDLE;
								code = TC_NEW_MESSAGE;
							end else
								arm_deadline(it.now_ms, reg_reply_ms);
						end
					end
					M_RESET_START: begin
						seq_reset_pending = 1'b0;
						seq_armed = 1'b0;
						send = SEND_RESET;
						seq_mode = M_RESET_WAIT;
					end
					M_RESET_WAIT: begin
						if (it.frame_valid && it.frame_kind == KIND_ATRESP && it.at_is_reset)
							seq_mode = M_START;
					end
					default: code = TC_ERROR;
				endcase
			end
		endcase
		res.tick_code = code;
		res.send_kind = send;
		res.sleep_request = seq_sleep_pin;
		return res;
	endfunction

	// Mostly no gap, sometimes a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH at %0t, result %0d, %s: got %0d, expected %0d",
			$realtime, results_seen, what, got, want);
		mismatches++;
	endtask

	// Sends one item and records its predicted result once it is accepted.
	// Called at a rising edge; returns at the edge where the item was taken.
	task automatic send_item(in_item_t it, cmd_t cmd);
		int gap;
		gap = steady_tx ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it;
		s_tuser <= cmd;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(seq_advance(it, cmd));
	endtask

	// Holds the input stream off until every owed result has come back, then
	// lets the pipeline settle with a little margin.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_ASSOC_TIMEOUT: reg_assoc_ms = value;
			CFG_REPLY_TIMEOUT: reg_reply_ms = value;
			CFG_EXPIRY_WINDOW: reg_window_ms = value;
			default: reg_max_retries = value[2:0];
		endcase
	endtask

	// All four registers, written only with the block empty.
	task automatic set_registers(logic [15:0] assoc_ms, logic [15:0] reply_ms,
		logic [15:0] window_ms, logic [2:0] max_retries);
		drain_results();
		write_reg(CFG_ASSOC_TIMEOUT, assoc_ms);
		write_reg(CFG_REPLY_TIMEOUT, reply_ms);
		write_reg(CFG_EXPIRY_WINDOW, window_ms);
		write_reg(CFG_MAX_RETRIES, {13'd0, max_retries});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Builds a tick item; flag sets all three frame status flags at once,
	// only the one that belongs to the frame kind matters.
	function automatic in_item_t frame(logic [31:0] now, bit fv, logic [2:0] kind,
		bit flag, logic [7:0] len, logic [7:0] first_b, logic [7:0] last_b, bit awake);
		in_item_t it;
		it = '0;
		it.now_ms = now;
		it.frame_valid = fv;
		it.frame_kind = kind;
		it.is_associated = flag;
		it.tx_ok = flag;
		it.at_is_reset = flag;
		it.rx_length = len;
		it.rx_first_byte = first_b;
		it.rx_last_byte = last_b;
		it.radio_awake = awake;
		return it;
	endfunction

	// Time stamps mostly creep forward; often they are put right on the edges
	// of the expiry window, and now and then the time base jumps near its wrap.
	function automatic logic [31:0] pick_now();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			radio_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
		else
			radio_ms = radio_ms + $urandom_range(0, 300);
		if (seq_armed && r >= 70) begin
			case ($urandom_range(0, 4))
				0: radio_ms = seq_deadline;
				1: radio_ms = seq_deadline + 32'd1;
				2: radio_ms = seq_deadline + {16'd0, reg_window_ms} - 32'd1;
				3: radio_ms = seq_deadline + {16'd0, reg_window_ms};
				default: radio_ms = seq_deadline +
					$urandom_range(1, int'(reg_window_ms) + 1);
			endcase
		end
		return radio_ms;
	endfunction

	// Random item shaped by the predicted state: most ticks carry the frame
	// that the current state waits for, with random content, so that the walk
	// gets deep into join, update and sleep. The rest is noise.
	task automatic make_random_item(output in_item_t it, output cmd_t cmd);
		int r;
		it = {$urandom, $urandom};
		cmd = CMD_TICK;
		r = $urandom_range(0, 99);
		if (seq_mode == M_ERROR && r < 30)
			cmd = CMD_JOIN;
		else if (seq_mode == M_SLEEPING && r < 35)
			cmd = ($urandom_range(0, 3) == 0) ? CMD_JOIN : CMD_WAKE;
		else if (seq_mode == M_IDLE && r < 40)
			cmd = CMD_UPDATE;
		else if (r < 6)
			cmd = cmd_t'($urandom_range(1, 3));
		if ($urandom_range(0, 9) != 0)
			it.now_ms = pick_now();
		if (cmd != CMD_TICK || $urandom_range(0, 99) >= 80)
			return;
		case (seq_mode)
			M_FORMING: begin
				it.frame_valid = 1'b1;
				it.frame_kind = KIND_MODEM;
				it.is_associated = ($urandom_range(0, 3) != 0);
			end
			M_JOIN_WAIT, M_REQ_STATUS: begin
				it.frame_valid = 1'b1;
				it.frame_kind = KIND_TXSTAT;
				it.tx_ok = ($urandom_range(0, 4) != 0);
			end
			M_JOIN_REPLY: begin
				it.frame_valid = 1'b1;
				it.frame_kind = KIND_RXDATA;
				if ($urandom_range(0, 9) < 7) begin
					it.rx_length = 8'd1;
					it.rx_first_byte = AckByte;
				end else if ($urandom_range(0, 1) == 0)
					it.rx_length = 8'd0;
			end
			M_SLEEP_WAIT: begin
				it.frame_valid = ($urandom_range(0, 4) == 0);
				it.radio_awake = ($urandom_range(0, 3) == 0);
			end
			M_REQ_WAIT: begin
				it.frame_valid = 1'b1;
				it.frame_kind = KIND_RXDATA;
				if ($urandom_range(0, 5) == 0)
					it.rx_length = 8'd0;
				else if ($urandom_range(0, 1) == 0)
					it.rx_last_byte = 8'd0;
			end
			M_RESET_WAIT: begin
				it.frame_valid = 1'b1;
				it.frame_kind = KIND_ATRESP;
				it.at_is_reset = ($urandom_range(0, 4) != 0);
			end
			default: ;
		endcase
	endtask

	task automatic run_random_phase(int count);
		in_item_t it;
		cmd_t     cmd;
		for (int i = 0; i < count; i++) begin
			if (i % 150 == 0) begin
				steady_tx = ($urandom_range(0, 3) == 0);
				steady_rx = ($urandom_range(0, 3) == 0);
			end
			// Occasionally stop sending until the block has answered everything.
			if ($urandom_range(0, 99) == 0)
				drain_results();
			make_random_item(it, cmd);
			send_item(it, cmd);
		end
	endtask

	// Association under the reset settings with a window that wraps past zero,
	// then the join handshake with undelivered, bad and zero-length replies.
	task automatic test_join_handshake();
		logic [31:0] dl;
		dl = 32'hFFFF_FF00;
		send_item(frame(dl - 32'd10000, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0),
			CMD_TICK);
		// At the deadline itself nothing has expired; an unknown kind is ignored.
		send_item(frame(dl, 1'b1, 3'd7, 1'b1, 8'd1, 8'd0, 8'd0, 1'b1), CMD_TICK);
		// After the wrap but still inside the window: association fails.
		send_item(frame(32'h100, 1'b1, KIND_MODEM, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		// Exactly at the end of the window the timeout no longer holds.
		send_item(frame(dl + 32'd1000, 1'b1, KIND_MODEM, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0),
			CMD_TICK);
		send_item(frame(32'd5, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd10, 1'b1, KIND_TXSTAT, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd100, 1'b1, KIND_TXSTAT, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd200, 1'b1, KIND_RXDATA, 1'b0, 8'd2, AckByte, 8'd0, 1'b0),
			CMD_TICK);
		send_item(frame(32'd300, 1'b1, KIND_RXDATA, 1'b0, 8'd0, AckByte, 8'd0, 1'b0),
			CMD_TICK);
		// A request item with every data bit set.
		send_item('1, CMD_UPDATE);
		send_item(frame(32'd400, 1'b1, KIND_RXDATA, 1'b0, 8'd1, AckByte, 8'hFF, 1'b0),
			CMD_TICK);
	endtask

	// Update request with an undelivered send, a zero-length frame that
	// re-arms the reply timer, one retry, the message itself, then the sleep
	// handshake with a join request parked until the radio sleeps.
	task automatic test_update_and_sleep();
		send_item('0, CMD_WAKE);
		send_item(frame(32'd500, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd550, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd600, 1'b1, KIND_TXSTAT, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd700, 1'b1, KIND_TXSTAT, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd800, 1'b1, KIND_RXDATA, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd5801, 1'b0, KIND_RXDATA, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0),
			CMD_TICK);
		send_item(frame(32'd5900, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd6000, 1'b1, KIND_TXSTAT, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd6100, 1'b1, KIND_RXDATA, 1'b0, 8'd5, 8'h33, 8'd0, 1'b0),
			CMD_TICK);
		send_item(frame(32'd6200, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd6300, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1), CMD_TICK);
		send_item('1, CMD_JOIN);
		send_item(frame(32'd6400, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd6500, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd6600, 1'b0, KIND_MODEM, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd6700, 1'b1, KIND_ATRESP, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
		send_item(frame(32'd6800, 1'b1, KIND_ATRESP, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0), CMD_TICK);
	endtask

	task automatic test_reset_registers();
		run_random_phase(250);
	endtask

	// Smallest register values (a window of one) and largest ones; with seven
	// retries allowed the saturated retry count never reaches the error state.
	task automatic test_register_extremes();
		set_registers(16'd0, 16'd0, 16'd1, 3'd0);
		run_random_phase(200);
		set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
		run_random_phase(250);
	endtask

	// A zero window means no deadline ever expires.
	task automatic test_zero_window();
		set_registers(16'd300, 16'd200, 16'd0, 3'd7);
		run_random_phase(100);
	endtask

	task automatic test_random_registers();
		logic [15:0] a_ms;
		logic [15:0] r_ms;
		logic [15:0] w_ms;
		logic [2:0]  m_retries;
		for (int p = 0; p < 3; p++) begin
			a_ms = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 2000) : $urandom);
			r_ms = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 2000) : $urandom);
			w_ms = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 500) :
				$urandom_range(1, 65535));
			m_retries = 3'($urandom_range(0, 7));
			set_registers(a_ms, r_ms, w_ms, m_retries);
			run_random_phase(185);
		end
	endtask

	// Result side: ready drops for random stretches unless a steady phase is on.
	always @(posedge clk) begin
		if (steady_rx)
			m_tready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			m_tready <= 1'b1;
		end
	end

	// Every accepted result is held against the oldest owed one.
	always @(posedge clk) begin : result_check
		out_item_t want;
		out_item_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = out_item_t'(m_tdata[6:0]);
			if (pending_results.size() == 0)
				report_mismatch("result with none owed", int'(m_tdata), 0);
			else begin
				want = pending_results.pop_front();
				if (got.tick_code != want.tick_code)
					report_mismatch("tick_code", int'(got.tick_code), int'(want.tick_code));
				if (got.send_kind != want.send_kind)
					report_mismatch("send_kind", int'(got.send_kind), int'(want.send_kind));
				if (got.sleep_request != want.sleep_request)
					report_mismatch("sleep_request", int'(got.sleep_request),
						int'(want.sleep_request));
				if (m_tdata[7] !== 1'b0)
					report_mismatch("pad bit", int'(m_tdata[7]), 0);
			end
			results_seen++;
		end
	end

	// Main sequence: one reset, the directed walk, the random phases, then a
	// full drain before the verdict.
	initial begin
		seq_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_join_handshake();
		test_update_and_sleep();
		test_reset_registers();
		test_register_extremes();
		test_zero_window();
		test_random_registers();
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run under the longest gaps.
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
